>>> rtl/core/prc_pkg.sv
`default_nettype none

package prc_pkg;

    localparam int BYTE_W     = 8;
    localparam int HASH_W     = 16;
    localparam int HASH_SHIFT = 4;
    localparam int GROUP_SIZE = 8;
    localparam int GPOS_W     = 3;
    localparam int LCNT_W     = 4;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [GPOS_W-1:0] t_gpos;
    typedef logic [LCNT_W-1:0] t_lcnt;

    typedef struct packed {
        t_byte data_byte;
        logic  end_of_buffer;
    } t_in_req;

    typedef struct packed {
        t_byte out_byte;
        logic  is_flag;
        logic  last;
    } t_out_req;

    // one finished group handed from the predictor to the output stage
    typedef struct packed {
        t_byte                   flags;
        t_byte [GROUP_SIZE-1:0]  lits;
        t_lcnt                   cnt;
        logic                    eob;
    } t_flush;

endpackage

`default_nettype wire

>>> rtl/core/prc_req_if.sv
`default_nettype none

interface prc_req_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/prc_emit.sv
`default_nettype none

module prc_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire prc_pkg::t_flush i_flush,
    output logic                 o_busy,
    prc_req_if.source            o_out
);
    import prc_pkg::*;

    logic   r_busy;
    t_lcnt  r_idx;
    t_flush r_flush;
    t_lcnt  lit_idx;
    logic   out_fire;
    logic   at_end;

    assign out_fire = o_out.valid && o_out.ready;
    assign at_end   = (r_idx == r_flush.cnt);
    assign lit_idx  = r_idx - t_lcnt'(1);
    assign o_busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_fire) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + t_lcnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flush <= i_flush;
        end
    end

    // flag byte first, then literals in arrival order
    always_comb begin
        o_out.valid            = r_busy;
        o_out.payload.is_flag  = (r_idx == '0);
        o_out.payload.last     = r_flush.eob && at_end;
        if (r_idx == '0) begin
            o_out.payload.out_byte = r_flush.flags;
        end else begin
            o_out.payload.out_byte = r_flush.lits[lit_idx[GPOS_W-1:0]];
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("group loaded while output stage busy");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_flush.cnt) && (r_flush.cnt <= t_lcnt'(GROUP_SIZE)))
        else $error("output index beyond literal count");

    a_keep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !at_end |=> r_busy && (r_idx == $past(r_idx) + t_lcnt'(1)))
        else $error("output stage dropped a group early");

endmodule

`default_nettype wire

>>> rtl/core/predictor_compressor.sv
`default_nettype none

// Channel   Dir  Payload                           Accepted when
// i_in      in   data_byte[7:0], end_of_buffer     i_in.valid  & i_in.ready
// o_out     out  out_byte[7:0], is_flag, last      o_out.valid & o_out.ready
//
// After reset the guess table is cleared, one entry a cycle, with i_in.ready
// low. Then one byte a cycle is taken, unless a group's closing byte waits
// as below: the table read is issued at acceptance and compared in the
// following cycle. A group's flag byte and literals (1 to 9 bytes) leave one
// a cycle while o_out.ready is high; the byte that closes a group waits while
// the previous group is still draining. Stalls on o_out never drop data;
// i_in.ready has no combinational path from o_out.ready.

module predictor_compressor #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prc_req_if.sink   i_in,
    prc_req_if.source o_out
);
    import prc_pkg::*;

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int MOD_W = HASH_W + 9;

    // guess table, one read and one write port
    t_byte mem [TABLE_ENTRIES];

    // clearing sweep
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // context hash and table index for the next request
    t_hash            r_hash;
    logic [MOD_W-1:0] rem;
    logic [AW-1:0]    rd_addr;

    // compare stage
    logic          r_s1_vld;
    t_byte         r_s1_byte;
    logic          r_s1_eob;
    logic [AW-1:0] r_s1_idx;
    t_byte         r_rd_data;
    logic          r_fwd_vld;
    t_byte         r_fwd_data;

    // group being built
    t_byte                  r_flags;
    t_gpos                  r_pos;
    t_lcnt                  r_lcnt;
    t_byte [GROUP_SIZE-1:0] r_queue;

    t_byte                  guess;
    logic                   hit;
    logic                   end_grp;
    logic                   s1_fire;
    logic                   acc;
    logic                   em_busy;
    logic                   em_load;
    t_flush                 em_flush;
    t_byte                  n_flags;
    t_lcnt                  n_lcnt;
    t_byte [GROUP_SIZE-1:0] n_queue;
    t_hash                  n_hash;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    t_byte                  mem_wdata;

    // index = hash mod TABLE_ENTRIES, restoring compare-subtract over 8 steps
    // (hash < 2^16 <= 256 * TABLE_ENTRIES)
    always_comb begin
        rem = MOD_W'(r_hash);
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (MOD_W'(TABLE_ENTRIES) << k)) begin
                rem = rem - (MOD_W'(TABLE_ENTRIES) << k);
            end
        end
        rd_addr = rem[AW-1:0];
    end

    // compare: the previous byte writes the table at the edge this read issued,
    // so a matching address takes its byte instead of the stale read
    assign guess   = r_fwd_vld ? r_fwd_data : r_rd_data;
    assign hit     = (guess == r_s1_byte);
    assign end_grp = (r_pos == t_gpos'(GROUP_SIZE - 1)) || r_s1_eob;
    assign s1_fire = r_s1_vld && (!end_grp || !em_busy);

    assign i_in.ready = !r_clr_busy && (!r_s1_vld || s1_fire);
    assign acc        = i_in.valid && i_in.ready;

    assign n_hash = t_hash'(r_hash << HASH_SHIFT) ^ t_hash'(i_in.payload.data_byte);

    always_comb begin
        n_flags = r_flags;
        n_lcnt  = r_lcnt;
        n_queue = r_queue;
        if (hit) begin
            n_flags = r_flags | (t_byte'(1) << r_pos);
        end else if (r_lcnt < t_lcnt'(GROUP_SIZE)) begin
            n_queue[r_lcnt[GPOS_W-1:0]] = r_s1_byte;
            n_lcnt = r_lcnt + t_lcnt'(1);
        end
    end

    assign em_load  = s1_fire && end_grp;
    assign em_flush = '{flags: n_flags, lits: n_queue, cnt: n_lcnt, eob: r_s1_eob};

    // table write: zero sweep after reset, else a mispredicted byte
    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_fire && !hit;
            mem_waddr = r_s1_idx;
            mem_wdata = r_s1_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (acc) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(TABLE_ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash    <= '0;
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_flags   <= '0;
            r_pos     <= '0;
            r_lcnt    <= '0;
        end else begin
            if (acc) begin
                r_hash    <= n_hash;
                r_s1_vld  <= 1'b1;
                r_fwd_vld <= s1_fire && (r_s1_idx == rd_addr);
            end else if (s1_fire) begin
                r_s1_vld  <= 1'b0;
                r_fwd_vld <= 1'b0;
            end
            if (s1_fire) begin
                if (end_grp) begin
                    r_flags <= '0;
                    r_pos   <= '0;
                    r_lcnt  <= '0;
                end else begin
                    r_flags <= n_flags;
                    r_pos   <= r_pos + t_gpos'(1);
                    r_lcnt  <= n_lcnt;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_byte  <= i_in.payload.data_byte;
            r_s1_eob   <= i_in.payload.end_of_buffer;
            r_s1_idx   <= rd_addr;
            r_fwd_data <= r_s1_byte;
        end
        if (s1_fire) begin
            r_queue <= n_queue;
        end
    end

    prc_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (em_load),
        .i_flush (em_flush),
        .o_busy  (em_busy),
        .o_out   (o_out)
    );

    a_no_work_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_vld && !em_busy)
        else $error("request in flight during table clear");

    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_vld |-> r_s1_vld)
        else $error("forwarding without a pending compare");

    a_lits_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_lcnt'(r_pos) >= r_lcnt)
        else $error("more literals than bytes in group");

    a_fwd_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s1_fire && (r_s1_idx == rd_addr) |=> r_fwd_vld)
        else $error("same-entry read missed forwarding");

endmodule

`default_nettype wire
